/* hw/rtl/http_chunked_transfer_decoder_macros.svh */
// Assertion macros for the chunked transfer decoder checker.
`ifndef HTTP_CHUNKED_TRANSFER_DECODER_MACROS_SVH
`define HTTP_CHUNKED_TRANSFER_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hctd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hctd assertion failed");

`endif

/* hw/rtl/hctd_pkg.sv */
// Package: types, constants and helpers of the chunked transfer decoder.
`timescale 1ns / 1ps
package hctd_pkg;

  localparam int unsigned LengthBitsDef = 32;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef enum logic [3:0] {
    PH_LENGTH,
    PH_EXTENSION,
    PH_HEADER_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAILER_START,
    PH_TRAILER,
    PH_TRAILER_LF,
    PH_FINAL_LF,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_end;
    status_e    status;
  } result_t;

  // Bit 4 set: not a hex digit. Otherwise bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0]} + 5'd9;
    end
    return v;
  endfunction

endpackage

/* hw/rtl/hctd_if.sv */
// Stream interfaces for the byte input and the result output.
`timescale 1ns / 1ps
interface hctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hctd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       chunk_end;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output payload_valid,
                  output chunk_end, output status, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input chunk_end, input status, output ready);
endinterface

/* hw/rtl/hctd_core.sv */
// Parser state machine with chunk length accumulator and down counter.
`timescale 1ns / 1ps
module hctd_core #(
  parameter int unsigned LENGTH_BITS = hctd_pkg::LengthBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output hctd_pkg::result_t result_o
);
  import hctd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] len_dec;
  logic [4:0]             digit;
  logic                   len_full;

  assign digit    = hex_value(data_byte_i);
  assign len_full = len_q[LENGTH_BITS-1 -: 4] != 4'd0;
  assign len_dec  = len_q - LENGTH_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LENGTH;
      len_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    phase_d                 = phase_q;
    len_d                   = len_q;
    result_o.payload_byte   = 8'd0;
    result_o.payload_valid  = 1'b0;
    result_o.chunk_end      = 1'b0;
    unique case (phase_q)
      PH_LENGTH: begin
        if (!digit[4]) begin
          if (len_full) begin
            phase_d = PH_ERROR;
          end else begin
            len_d = {len_q[LENGTH_BITS-5:0], digit[3:0]};
          end
        end else if (data_byte_i == ChSemi) begin
          phase_d = PH_EXTENSION;
        end else if (data_byte_i == ChCr) begin
          phase_d = PH_HEADER_LF;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_EXTENSION: begin
        if (data_byte_i == ChCr) phase_d = PH_HEADER_LF;
      end
      PH_HEADER_LF: begin
        if (data_byte_i != ChLf) phase_d = PH_ERROR;
        else if (len_q != '0) phase_d = PH_DATA;
        else phase_d = PH_TRAILER_START;
      end
      PH_DATA: begin
        result_o.payload_byte  = data_byte_i;
        result_o.payload_valid = 1'b1;
        len_d                  = len_dec;
        if (len_dec == '0) begin
          result_o.chunk_end = 1'b1;
          phase_d            = PH_DATA_CR;
        end
      end
      PH_DATA_CR: phase_d = (data_byte_i == ChCr) ? PH_DATA_LF : PH_ERROR;
      PH_DATA_LF: phase_d = (data_byte_i == ChLf) ? PH_LENGTH : PH_ERROR;
      PH_TRAILER_START: phase_d = (data_byte_i == ChCr) ? PH_FINAL_LF : PH_TRAILER;
      PH_TRAILER: begin
        if (data_byte_i == ChCr) phase_d = PH_TRAILER_LF;
      end
      PH_TRAILER_LF: phase_d = (data_byte_i == ChLf) ? PH_TRAILER_START : PH_ERROR;
      PH_FINAL_LF: phase_d = (data_byte_i == ChLf) ? PH_DONE : PH_ERROR;
      default: phase_d = PH_ERROR;
    endcase

    if (phase_d == PH_ERROR) result_o.status = ST_ERROR;
    else if (phase_d == PH_DONE) result_o.status = ST_DONE;
    else result_o.status = ST_BUSY;
  end

endmodule

/* hw/rtl/hctd_obuf.sv */
// Result register with valid/ready handshake toward the sink.
`timescale 1ns / 1ps
module hctd_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hctd_pkg::result_t result_i,
  output logic              ready_o,
  hctd_out_if.source        out_o
);
  import hctd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= result_i;
  end

  assign out_o.valid         = valid_q;
  assign out_o.payload_byte  = res_q.payload_byte;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.chunk_end     = res_q.chunk_end;
  assign out_o.status        = res_q.status;

endmodule

/* hw/rtl/http_chunked_transfer_decoder.sv */
// Top level: HTTP/1.1 chunked transfer body decoder, one byte per beat.
// One result beat per input beat, registered and valid in the cycle after acceptance.
// One byte per cycle while the sink keeps taking results; the phase and length registers update on each accepted byte.
// The result register accepts a new beat while the sink takes the previous one.
// Reset (async, active low) returns to the chunk size line with a zero length
// and empties the result register.
`timescale 1ns / 1ps
module http_chunked_transfer_decoder #(
  parameter int unsigned LENGTH_BITS = hctd_pkg::LengthBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hctd_in_if.sink    in_i,
  hctd_out_if.source out_o
);
  import hctd_pkg::*;

  logic    ready;
  logic    accept;
  result_t result;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  hctd_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(in_i.data_byte),
    .result_o   (result)
  );

  hctd_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .result_i(result),
    .ready_o (ready),
    .out_o   (out_o)
  );

endmodule

/* hw/rtl/hctd_checker.sv */
// Port-level checker for the chunked transfer decoder, with its bind.
`timescale 1ns / 1ps
`include "http_chunked_transfer_decoder_macros.svh"
module hctd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_payload_byte_i,
  input logic       out_payload_valid_i,
  input logic       out_chunk_end_i,
  input logic [1:0] out_status_i
);
  import hctd_pkg::*;

  logic seen_err_q;
  logic out_beat;

  assign out_beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_err_q <= 1'b0;
    end else if (out_beat && out_status_i == ST_ERROR) begin
      seen_err_q <= 1'b1;
    end
  end

  `HCTD_ASSERT_IMPL(a_payload_busy, clk_i, rst_ni, out_valid_i && out_payload_valid_i, out_status_i == ST_BUSY)
  `HCTD_ASSERT_IMPL(a_end_has_payload, clk_i, rst_ni, out_valid_i && out_chunk_end_i, out_payload_valid_i)
  `HCTD_ASSERT_IMPL(a_idle_byte_zero, clk_i, rst_ni, out_valid_i && !out_payload_valid_i, out_payload_byte_i == 8'd0)
  `HCTD_ASSERT_IMPL(a_error_sticky, clk_i, rst_ni, out_valid_i && seen_err_q, out_status_i == ST_ERROR && !out_payload_valid_i)
  `HCTD_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind http_chunked_transfer_decoder hctd_checker u_hctd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_payload_byte_i (out_o.payload_byte),
  .out_payload_valid_i(out_o.payload_valid),
  .out_chunk_end_i    (out_o.chunk_end),
  .out_status_i       (out_o.status)
);

/* test/hctd_checker.sv */
// Checker for the chunked transfer decoder: predicts every result beat and compares it.
`timescale 1ns / 1ps
module hctd_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  hctd_in_if   in_i,
  hctd_out_if  out_i,
  output int   err_cnt_o,
  output int   pending_o
);
  import hctd_pkg::*;

  localparam int unsigned LenW = LengthBitsDef;

  phase_e          phase_q;
  logic [LenW-1:0] left_q;
  result_t         decoded_q[$];

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
    return 5'h10;
  endfunction

  // Advances the parser by one body byte and returns the beat it should produce.
  function automatic result_t decode_byte(logic [7:0] c);
    result_t    r;
    logic [4:0] dig;
    r = '0;
    dig = nibble_of(c);
    case (phase_q)
      PH_LENGTH: begin
        if (!dig[4]) begin
          if (left_q[LenW-1 -: 4] != 4'h0) begin
            phase_q = PH_ERROR;
          end else begin
            left_q = {left_q[LenW-5:0], dig[3:0]};
          end
        end else if (c == ChSemi) begin
          phase_q = PH_EXTENSION;
        end else if (c == ChCr) begin
          phase_q = PH_HEADER_LF;
        end else begin
          phase_q = PH_ERROR;
        end
      end
      PH_EXTENSION: begin
        if (c == ChCr) phase_q = PH_HEADER_LF;
      end
      PH_HEADER_LF: begin
        if (c != ChLf) begin
          phase_q = PH_ERROR;
        end else if (left_q != '0) begin
          phase_q = PH_DATA;
        end else begin
          phase_q = PH_TRAILER_START;
        end
      end
      PH_DATA: begin
        r.payload_byte  = c;
        r.payload_valid = 1'b1;
        left_q = left_q - LenW'(1);
        if (left_q == '0) begin
          r.chunk_end = 1'b1;
          phase_q = PH_DATA_CR;
        end
      end
      PH_DATA_CR:       phase_q = (c == ChCr) ? PH_DATA_LF : PH_ERROR;
      PH_DATA_LF:       phase_q = (c == ChLf) ? PH_LENGTH : PH_ERROR;
      PH_TRAILER_START: phase_q = (c == ChCr) ? PH_FINAL_LF : PH_TRAILER;
      PH_TRAILER: begin
        if (c == ChCr) phase_q = PH_TRAILER_LF;
      end
      PH_TRAILER_LF:    phase_q = (c == ChLf) ? PH_TRAILER_START : PH_ERROR;
      PH_FINAL_LF:      phase_q = (c == ChLf) ? PH_DONE : PH_ERROR;
      default:          phase_q = PH_ERROR;
    endcase
    if (phase_q == PH_ERROR) begin
      r.status = ST_ERROR;
    end else if (phase_q == PH_DONE) begin
      r.status = ST_DONE;
    end else begin
      r.status = ST_BUSY;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      phase_q = PH_LENGTH;
      left_q  = '0;
      decoded_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with no input byte outstanding");
          err_cnt_o++;
        end else begin
          want = decoded_q.pop_front();
          check_field("payload_byte", want.payload_byte, out_i.payload_byte);
          check_field("payload_valid", 8'(want.payload_valid), 8'(out_i.payload_valid));
          check_field("chunk_end", 8'(want.chunk_end), 8'(out_i.chunk_end));
          check_field("status", 8'(want.status), 8'(out_i.status));
        end
      end
      if (in_i.valid && in_i.ready) begin
        decoded_q.push_back(decode_byte(in_i.data_byte));
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

/* test/tb_http_chunked_transfer_decoder.sv */
// Testbench top: builds a chunked body, streams it into the decoder and gives the verdict.
`timescale 1ns / 1ps
module tb_http_chunked_transfer_decoder;
  import hctd_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned SteadyLo    = 150;
  localparam int unsigned SteadyHi    = 300;
  localparam int unsigned BodyBytes   = 480;

  typedef enum int unsigned {
    END_COMPLETE,
    END_OVERFLOW,
    END_BAD_SIZE,
    END_BAD_HEADER_LF,
    END_BAD_DATA_CR,
    END_BAD_DATA_LF,
    END_BAD_TRAILER
  } ending_e;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  int          err_cnt;
  int          pending;
  int unsigned quiet_cycles;
  logic [7:0]  body_q[$];

  hctd_in_if  byte_if ();
  hctd_out_if res_if ();

  http_chunked_transfer_decoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (res_if)
  );

  hctd_scoreboard u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (byte_if),
    .out_i    (res_if),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // Random byte other than avoid; in_size also rules out hex digits and ';'.
  function automatic logic [7:0] stray_byte(logic [7:0] avoid, bit in_size);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == avoid || (in_size && ((c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66) || c == ChSemi))) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic void push_crlf();
    body_q.push_back(ChCr);
    body_q.push_back(ChLf);
  endfunction

  function automatic void push_payload(int unsigned n);
    repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Size 0 with no leading zeros gives a size line with no digits.
  function automatic void push_size_line(int unsigned size, int unsigned zeros, bit with_ext);
    logic [7:0]  digits[$];
    int unsigned v;
    v = size;
    while (v != 0) begin
      digits.push_front(hex_char(v[3:0]));
      v = v >> 4;
    end
    repeat (zeros) body_q.push_back(8'h30);
    foreach (digits[i]) body_q.push_back(digits[i]);
    if (with_ext) begin
      body_q.push_back(ChSemi);
      repeat ($urandom_range(0, 5)) body_q.push_back(stray_byte(ChCr, 1'b0));
    end
    push_crlf();
  endfunction

  function automatic void push_last_chunk();
    push_size_line(0, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) begin
      body_q.push_back(stray_byte(ChCr, 1'b0));
      repeat ($urandom_range(0, 6)) body_q.push_back(stray_byte(ChCr, 1'b0));
      push_crlf();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 38) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    ending_e     ending;
    int unsigned pick;
    int unsigned n;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    rst_ni            = 1'b0;
    steady            = 1'b0;

    // opening: one-byte chunk, eight-digit size line, payload full of framing bytes
    push_size_line(1, 0, 1'b1);
    body_q.push_back(8'hFF);
    push_crlf();
    push_size_line(2, 7, 1'b1);
    body_q.push_back(8'h00);
    body_q.push_back(ChCr);
    push_crlf();
    push_size_line(3, 0, 1'b0);
    body_q.push_back(ChLf);
    body_q.push_back(ChSemi);
    body_q.push_back(8'h80);
    push_crlf();

    while (body_q.size() < BodyBytes) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      if (body_q.size() + n > BodyBytes) n = BodyBytes - body_q.size();
      push_size_line(n, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0,
                     $urandom_range(0, 3) == 0);
      push_payload(n);
      push_crlf();
    end

    pick   = $urandom_range(0, 10);
    ending = (pick < 5) ? END_COMPLETE : ending_e'(pick - 4);
    case (ending)
      END_COMPLETE: begin
        push_last_chunk();
        push_crlf();
      end
      END_OVERFLOW: begin
        repeat (8) body_q.push_back(hex_char(4'hF));
        body_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      END_BAD_SIZE: begin
        repeat ($urandom_range(0, 2)) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        body_q.push_back(stray_byte(ChCr, 1'b1));
      end
      END_BAD_HEADER_LF: begin
        body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        body_q.push_back(ChCr);
        body_q.push_back(stray_byte(ChLf, 1'b0));
      end
      END_BAD_DATA_CR, END_BAD_DATA_LF: begin
        n = $urandom_range(1, 16);
        push_size_line(n, 0, 1'b0);
        push_payload(n);
        if (ending == END_BAD_DATA_CR) begin
          body_q.push_back(stray_byte(ChCr, 1'b0));
        end else begin
          body_q.push_back(ChCr);
          body_q.push_back(stray_byte(ChLf, 1'b0));
        end
      end
      default: begin
        push_last_chunk();
        body_q.push_back(ChCr);
        body_q.push_back(stray_byte(ChLf, 1'b0));
      end
    endcase
    // bytes past completion or past an error
    push_payload(4);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < body_q.size(); i++) begin
      if (i == body_q.size() / 2) begin
        byte_if.valid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      steady <= (i >= SteadyLo && i < SteadyHi);
      send_byte(body_q[i]);
    end
    byte_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
